/* src/keyed_table_oldest_eviction_unit_macros.svh */
// Assertion helpers; clocked on clk, quiet while arst_n is low.
`ifndef KEYED_TABLE_OLDEST_EVICTION_UNIT_MACROS_SVH
`define KEYED_TABLE_OLDEST_EVICTION_UNIT_MACROS_SVH

// cond in this cycle implies conseq in the same cycle
`define KTOE_ASSERT_NOW(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// cond in this cycle implies conseq in the next cycle
`define KTOE_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

/* src/ktoe_pkg.sv */
package ktoe_pkg;

	localparam int TABLE_SLOTS_DEF = 16;
	localparam int KEY_W           = 32;
	localparam int TIME_W          = 32;
	localparam int SLOT_IDX_W      = 4;
	localparam int COUNT_W         = 5;

	typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
	typedef logic [COUNT_W-1:0]    count_t;

	typedef enum logic [1:0] {
		OUT_MATCH = 2'd0,
		OUT_NEW   = 2'd1,
		OUT_EVICT = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]  node_key;
		logic              entry_kind;
		logic [TIME_W-1:0] now_time;
	} item_t;

	typedef struct packed {
		slot_idx_t slot_index;
		outcome_t  outcome;
		count_t    occupied_count;
	} result_t;

endpackage

/* src/keyed_table_oldest_eviction_unit.sv */
// Keyed table with oldest-time replacement. A word is taken at a rising edge with start high
// and busy low; busy then stays high through the scan, last and write states while one
// compare unit walks the slot memory through its single read port, one slot per
// cycle, looking for a key/kind match, the lowest free slot and the oldest last-seen time
// at once. The result word appears on result with done high for exactly one cycle, the
// cycle right after busy falls; the receiver cannot stall it, and a new word may be started
// in that same cycle, though no new word is taken while busy. slot_index holds the low four
// bits of the slot number; occupied_count wraps at 32.
`include "keyed_table_oldest_eviction_unit_macros.svh"

module keyed_table_oldest_eviction_unit #(
	parameter int TABLE_SLOTS = ktoe_pkg::TABLE_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ktoe_pkg::item_t   item,
	output logic              done,
	output ktoe_pkg::result_t result
);

	localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

	typedef logic [IW-1:0] idx_t;

	typedef struct packed {
		logic                        kind;
		logic [ktoe_pkg::KEY_W-1:0]  key;
		logic [ktoe_pkg::TIME_W-1:0] last_seen;
	} slot_word_t;

	slot_word_t slot_mem [TABLE_SLOTS];

	ktoe_pkg::state_t   state_q, state_d;
	idx_t               idx_q;
	ktoe_pkg::item_t    item_q;
	logic [TABLE_SLOTS-1:0] used_q;
	ktoe_pkg::count_t   fill_q;

	slot_word_t         rd_s1;
	idx_t               rd_idx_s1;
	logic               rd_vld_s1;

	logic               hit_q, free_q;
	idx_t               hit_idx_q, free_idx_q, old_idx_q;
	logic [ktoe_pkg::TIME_W-1:0] old_time_q;

	logic               done_q;
	ktoe_pkg::result_t  result_q;

	logic               accept;
	logic               key_match, older, first_slot;
	idx_t               chosen;
	ktoe_pkg::outcome_t outcome_sel;
	slot_word_t         wr_word;
	logic               alloc;

	assign accept = start && (state_q == ktoe_pkg::ST_IDLE);
	assign busy   = (state_q != ktoe_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// shared compare unit: one slot per cycle
	assign key_match  = used_q[rd_idx_s1] && (rd_s1.kind == item_q.entry_kind)
		&& (rd_s1.key == item_q.node_key);
	assign older      = rd_s1.last_seen < old_time_q;
	assign first_slot = (rd_idx_s1 == '0);

	always_comb begin
		if (hit_q) begin
			chosen      = hit_idx_q;
			outcome_sel = ktoe_pkg::OUT_MATCH;
		end else if (free_q) begin
			chosen      = free_idx_q;
			outcome_sel = ktoe_pkg::OUT_NEW;
		end else begin
			chosen      = old_idx_q;
			outcome_sel = ktoe_pkg::OUT_EVICT;
		end
	end

	assign alloc   = !hit_q && free_q;
	assign wr_word = '{kind: item_q.entry_kind, key: item_q.node_key,
		last_seen: item_q.now_time};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ktoe_pkg::ST_IDLE: begin
				if (start) state_d = ktoe_pkg::ST_SCAN;
			end
			ktoe_pkg::ST_SCAN: begin
				if (idx_q == idx_t'(TABLE_SLOTS - 1)) state_d = ktoe_pkg::ST_LAST;
			end
			ktoe_pkg::ST_LAST:  state_d = ktoe_pkg::ST_WRITE;
			ktoe_pkg::ST_WRITE: state_d = ktoe_pkg::ST_IDLE;
			default:            state_d = ktoe_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ktoe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			used_q    <= '0;
			fill_q    <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ktoe_pkg::ST_SCAN);
			done_q    <= (state_q == ktoe_pkg::ST_WRITE);
			if (accept) begin
				idx_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (state_q == ktoe_pkg::ST_SCAN) begin
				idx_q <= idx_q + idx_t'(1);
			end
			if (rd_vld_s1) begin
				if (!hit_q && key_match) hit_q <= 1'b1;
				if (!free_q && !used_q[rd_idx_s1]) free_q <= 1'b1;
			end
			if (state_q == ktoe_pkg::ST_WRITE) begin
				used_q[chosen] <= 1'b1;
				if (alloc) fill_q <= fill_q + ktoe_pkg::count_t'(1);
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) item_q <= item;
		if (rd_vld_s1) begin
			if (!hit_q && key_match) hit_idx_q <= rd_idx_s1;
			if (!free_q && !used_q[rd_idx_s1]) free_idx_q <= rd_idx_s1;
			// strict compare keeps the lowest index on a tie
			if (first_slot || older) begin
				old_idx_q  <= rd_idx_s1;
				old_time_q <= rd_s1.last_seen;
			end
		end
		if (state_q == ktoe_pkg::ST_WRITE) begin
			result_q.slot_index     <= ktoe_pkg::slot_idx_t'(chosen);
			result_q.outcome        <= outcome_sel;
			result_q.occupied_count <= alloc ? fill_q + ktoe_pkg::count_t'(1) : fill_q;
		end
	end

	// slot memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (state_q == ktoe_pkg::ST_WRITE) slot_mem[chosen] <= wr_word;
		rd_s1     <= slot_mem[idx_q];
		rd_idx_s1 <= idx_q;
	end

	`KTOE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`KTOE_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")
	`KTOE_ASSERT_NOW(a_evict_full, (state_q == ktoe_pkg::ST_WRITE) && !hit_q && !free_q,
		&used_q, "eviction with a free slot")
	`KTOE_ASSERT_NEXT(a_fill_step, (state_q == ktoe_pkg::ST_WRITE) && alloc,
		fill_q == $past(fill_q) + ktoe_pkg::count_t'(1), "fill count did not advance")

endmodule
